>>> src/nmst_pkg.sv
// ----------------------------------------------------------------------------
// nmst_pkg: shared types and constants of the detection NMS table
// Entry layout, outcome codes, controller states and the overlap unit's
// pipeline depth.
// ----------------------------------------------------------------------------
package nmst_pkg;

   // Default table depth.
   localparam int NMST_MAX_ENTRIES = 64;

   // Reset value of the overlap threshold (one half).
   localparam logic [15:0] NMST_THR_RESET = 16'd32768;

   // Pipeline depth of the overlap unit, and the width of the drain counter.
   localparam int NMST_IOU_LAT = 5;
   localparam int NMST_DRAIN_W = $clog2(NMST_IOU_LAT);

   // Width of the slot field on the result channel.
   localparam int NMST_SLOT_W = 6;

   // One kept detection.
   typedef struct packed {
      logic [15:0] label;
      logic [15:0] conf;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
   } entry_type;

   // Result of one comparison from the overlap unit.
   typedef struct packed {
      logic valid;
      logic hit;
      logic gt;
   } iou_res_type;

   // Outcome codes on the result channel.
   typedef enum logic [2:0] {
      OUT_APPEND  = 3'd0,
      OUT_REPLACE = 3'd1,
      OUT_SUPPR   = 3'd2,
      OUT_FULL    = 3'd3,
      OUT_FLUSHED = 3'd4,
      OUT_EMPTY   = 3'd5
   } outcome_type;

   // Input opcodes.
   typedef enum logic {
      OP_SUBMIT = 1'b0,
      OP_FLUSH  = 1'b1
   } opcode_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

endpackage

>>> src/detection_nms_table.sv
// ----------------------------------------------------------------------------
// detection_nms_table: online non-maximum suppression over a kept table
// Submit: the outcome is decided by one full turn of the entry ring through
// the shared five-stage overlap unit.
// Flush: one result beat per kept entry, one per cycle while the result
// channel does not stall, or a single marker beat if the table is empty.
// One item is in work at a time. Reset empties the table and sets the
// threshold to one half; the stored entries themselves are not cleared.
// ----------------------------------------------------------------------------
module detection_nms_table
   import nmst_pkg::*;
#(
   parameter int MAX_ENTRIES = NMST_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_opcode,
   input  logic [15:0] req_label,
   input  logic [15:0] req_confidence,
   input  logic [15:0] req_box_left,
   input  logic [15:0] req_box_top,
   input  logic [15:0] req_box_right,
   input  logic [15:0] req_box_bottom,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_outcome,
   output logic [5:0]  rsp_slot,
   output logic [15:0] rsp_out_label,
   output logic [15:0] rsp_out_confidence,
   output logic [15:0] rsp_out_left,
   output logic [15:0] rsp_out_top,
   output logic [15:0] rsp_out_right,
   output logic [15:0] rsp_out_bottom,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_iou_threshold
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic [IDX_W-1:0] fidx_ff, fidx_in;
   logic found_ff, found_in, fgt_ff, fgt_in;
   logic [NMST_DRAIN_W-1:0] drain_ff, drain_in;
   logic [15:0] thr_ff;
   entry_type query_ff, query_in;

   logic rsp_valid_ff, rsp_valid_in;
   outcome_type out_code_ff, out_code_in;
   logic [NMST_SLOT_W-1:0] out_slot_ff, out_slot_in;
   entry_type out_entry_ff, out_entry_in;
   logic out_last_ff, out_last_in;

   logic shift;
   logic wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic feed_valid;
   logic slot_free;
   logic req_take;
   logic pos_end;
   logic pos_live;
   entry_type ring [MAX_ENTRIES];
   iou_res_type res;

   // The ring of entry cells; each hands its entry to its lower neighbour.
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      nmst_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .load       (wr_en && (wr_idx == IDX_W'(k))),
         .shift_data (ring[(k + 1) % MAX_ENTRIES]),
         .load_data  (query_ff),
         .entry      (ring[k])
      );
   end

   // Shared overlap unit, fed from the head of the ring.
   nmst_iou u_iou (
      .clock      (clock),
      .reset      (reset),
      .feed_valid (feed_valid),
      .query      (query_ff),
      .kept       (ring[0]),
      .threshold  (thr_ff),
      .res        (res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pos_end   = (pos_ff == IDX_W'(MAX_ENTRIES - 1));
   assign pos_live  = (CNT_W'(pos_ff) < count_ff);
   assign csr_ready = 1'b1;

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      res_idx_in   = res_idx_ff;
      fidx_in      = fidx_ff;
      found_in     = found_ff;
      fgt_in       = fgt_ff;
      drain_in     = drain_ff;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_code_in  = out_code_ff;
      out_slot_in  = out_slot_ff;
      out_entry_in = out_entry_ff;
      out_last_in  = out_last_ff;
      shift        = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = fidx_ff;
      feed_valid   = 1'b0;

      // Comparison results arrive in index order; the first hit decides.
      if (res.valid) begin
         res_idx_in = res_idx_ff + 1'b1;
         if (res.hit && !found_ff) begin
            found_in = 1'b1;
            fidx_in  = res_idx_ff;
            fgt_in   = res.gt;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               query_in   = '{label: req_label, conf: req_confidence,
                              left: req_box_left, top: req_box_top,
                              right: req_box_right, bottom: req_box_bottom};
               pos_in     = '0;
               res_idx_in = '0;
               found_in   = 1'b0;
               state_in   = (opcode_type'(req_opcode) == OP_FLUSH) ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // One full turn of the ring; only live entries are compared.
            shift      = 1'b1;
            feed_valid = pos_live;
            pos_in     = pos_ff + 1'b1;
            if (pos_end) begin
               pos_in   = '0;
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == NMST_DRAIN_W'(NMST_IOU_LAT - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_entry_in = '0;
               out_last_in  = 1'b1;
               out_slot_in  = '0;
               state_in     = ST_IDLE;
               if (found_ff && fgt_ff) begin
                  wr_en       = 1'b1;
                  wr_idx      = fidx_ff;
                  out_code_in = OUT_REPLACE;
                  out_slot_in = NMST_SLOT_W'(fidx_ff);
               end else if (found_ff) begin
                  out_code_in = OUT_SUPPR;
               end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                  out_code_in = OUT_FULL;
               end else begin
                  wr_en       = 1'b1;
                  wr_idx      = count_ff[IDX_W-1:0];
                  count_in    = count_ff + 1'b1;
                  out_code_in = OUT_APPEND;
                  out_slot_in = NMST_SLOT_W'(count_ff[IDX_W-1:0]);
               end
            end
         end
         ST_FLUSH: begin
            if (count_ff == '0) begin
               // Empty table: a single marker beat.
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  out_code_in  = OUT_EMPTY;
                  out_slot_in  = '0;
                  out_entry_in = '0;
                  out_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (slot_free || !pos_live) begin
               // Rotate the ring, emitting the live entries on the way.
               shift  = 1'b1;
               pos_in = pos_ff + 1'b1;
               if (pos_live) begin
                  rsp_valid_in = 1'b1;
                  out_code_in  = OUT_FLUSHED;
                  out_slot_in  = NMST_SLOT_W'(pos_ff);
                  out_entry_in = ring[0];
                  out_last_in  = (CNT_W'(pos_ff) == count_ff - 1'b1);
               end
               if (pos_end) begin
                  pos_in   = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         res_idx_ff   <= '0;
         found_ff     <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= NMST_THR_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         res_idx_ff   <= res_idx_in;
         found_ff     <= found_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_iou_threshold;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      fidx_ff      <= fidx_in;
      fgt_ff       <= fgt_in;
      out_code_ff  <= out_code_in;
      out_slot_ff  <= out_slot_in;
      out_entry_ff <= out_entry_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = out_code_ff;
   assign rsp_slot           = out_slot_ff;
   assign rsp_out_label      = out_entry_ff.label;
   assign rsp_out_confidence = out_entry_ff.conf;
   assign rsp_out_left       = out_entry_ff.left;
   assign rsp_out_top        = out_entry_ff.top;
   assign rsp_out_right      = out_entry_ff.right;
   assign rsp_out_bottom     = out_entry_ff.bottom;
   assign rsp_last           = out_last_ff;

`ifndef SYNTH
   // The table never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table depth");

   // A deciding hit always points at a live entry.
   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && found_ff) |-> (CNT_W'(fidx_ff) < count_ff))
      else $error("deciding entry beyond the table fill");

   // Comparison results only arrive while a submit is in work.
   a_res_window: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("overlap result outside a scan");

   // An accepted flush starts the flush sequence.
   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_opcode == OP_FLUSH) |=> (state_ff == ST_FLUSH))
      else $error("flush beat did not start a flush");
`endif

endmodule

>>> src/nmst_cell.sv
// ----------------------------------------------------------------------------
// nmst_cell: one storage cell of the entry ring
// Holds one kept entry. It either takes a new entry from the write port or
// takes its neighbour's entry when the ring rotates.
// ----------------------------------------------------------------------------
module nmst_cell
   import nmst_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  logic      load,
   input  entry_type shift_data,
   input  entry_type load_data,
   output entry_type entry
);

   entry_type entry_ff;

   // A direct write wins over rotation; the two never coincide in practice.
   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= load_data;
      end else if (shift) begin
         entry_ff <= shift_data;
      end
   end

   assign entry = entry_ff;

endmodule

>>> src/nmst_iou.sv
// ----------------------------------------------------------------------------
// nmst_iou: pipelined overlap test
// Compares the query with one kept entry per cycle: label match, box overlap
// against the threshold (intersection * 65536 > threshold * union) and
// confidence order. Five register stages, results in feed order.
// ----------------------------------------------------------------------------
module nmst_iou
   import nmst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        feed_valid,
   input  entry_type   query,
   input  entry_type   kept,
   input  logic [15:0] threshold,
   output iou_res_type res
);

   logic [15:0] min_r, max_l, min_b, max_t;
   logic [15:0] qw_in, qh_in, kw_in, kh_in;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        ovl1_ff, lbl1_ff, gt1_ff;
   logic [15:0] iw1_ff, ih1_ff, qw1_ff, qh1_ff, kw1_ff, kh1_ff;
   logic        ok2_ff, gt2_ff;
   logic [31:0] inter2_ff, qa2_ff, ka2_ff;
   logic        ok3_ff, gt3_ff;
   logic [31:0] inter3_ff;
   logic [32:0] uni3_ff;
   logic        ok4_ff, gt4_ff;
   logic [31:0] inter4_ff;
   logic [48:0] prod4_ff;
   logic        res_valid_ff, res_hit_ff, res_gt_ff;

   // Edge selection and box extents.
   always_comb begin
      min_r = (query.right  < kept.right)  ? query.right  : kept.right;
      max_l = (query.left   > kept.left)   ? query.left   : kept.left;
      min_b = (query.bottom < kept.bottom) ? query.bottom : kept.bottom;
      max_t = (query.top    > kept.top)    ? query.top    : kept.top;
      qw_in = (query.right  > query.left)  ? query.right  - query.left : 16'd0;
      qh_in = (query.bottom > query.top)   ? query.bottom - query.top  : 16'd0;
      kw_in = (kept.right   > kept.left)   ? kept.right   - kept.left  : 16'd0;
      kh_in = (kept.bottom  > kept.top)    ? kept.bottom  - kept.top   : 16'd0;
   end

   // Valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= feed_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         res_valid_ff <= v4_ff;
      end
   end

   // Datapath stages.
   always_ff @(posedge clock) begin
      // Stage 1: extents and flags.
      ovl1_ff <= (min_r > max_l) && (min_b > max_t);
      lbl1_ff <= (query.label == kept.label);
      gt1_ff  <= (query.conf > kept.conf);
      iw1_ff  <= min_r - max_l;
      ih1_ff  <= min_b - max_t;
      qw1_ff  <= qw_in;
      qh1_ff  <= qh_in;
      kw1_ff  <= kw_in;
      kh1_ff  <= kh_in;
      // Stage 2: intersection and both areas.
      ok2_ff    <= ovl1_ff && lbl1_ff;
      gt2_ff    <= gt1_ff;
      inter2_ff <= iw1_ff * ih1_ff;
      qa2_ff    <= qw1_ff * qh1_ff;
      ka2_ff    <= kw1_ff * kh1_ff;
      // Stage 3: union.
      ok3_ff    <= ok2_ff;
      gt3_ff    <= gt2_ff;
      inter3_ff <= inter2_ff;
      uni3_ff   <= {1'b0, qa2_ff} + {1'b0, ka2_ff} - {1'b0, inter2_ff};
      // Stage 4: threshold times union.
      ok4_ff    <= ok3_ff;
      gt4_ff    <= gt3_ff;
      inter4_ff <= inter3_ff;
      prod4_ff  <= {33'd0, threshold} * {16'd0, uni3_ff};
      // Stage 5: final compare.
      res_hit_ff <= ok4_ff && ({1'b0, inter4_ff, 16'd0} > prod4_ff);
      res_gt_ff  <= gt4_ff;
   end

   assign res = '{valid: res_valid_ff, hit: res_hit_ff, gt: res_gt_ff};

endmodule
